// ===== rtl/dmfp_pkg.sv =====
// Package for the display message frame parser: codes, widths and the result word type.
`default_nettype none
package dmfp_pkg;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes
  localparam logic [1:0] REG_START     = 2'd0;
  localparam logic [1:0] REG_ID        = 2'd1;
  localparam logic [1:0] REG_ELEM_END  = 2'd2;
  localparam logic [1:0] REG_XFER_END  = 2'd3;

  localparam logic [7:0] START_RESET    = 8'd35;
  localparam logic [7:0] ID_RESET       = 8'd49;
  localparam logic [7:0] ELEM_END_RESET = 8'd36;
  localparam logic [7:0] XFER_END_RESET = 8'd37;

  // Parser states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ID     = 4'd1;
  localparam logic [3:0] ST_COUNT  = 4'd2;
  localparam logic [3:0] ST_DIGITS = 4'd3;
  localparam logic [3:0] ST_KIND   = 4'd4;
  localparam logic [3:0] ST_SPEED  = 4'd5;
  localparam logic [3:0] ST_LEN    = 4'd6;
  localparam logic [3:0] ST_TEXT   = 4'd7;
  localparam logic [3:0] ST_ELEND  = 4'd8;
  localparam logic [3:0] ST_TXEND  = 4'd9;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_END  = 2'd2;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_TEXT   = 3'd1;
  localparam logic [2:0] EV_ELEM   = 3'd2;
  localparam logic [2:0] EV_COMMIT = 3'd3;
  localparam logic [2:0] EV_ABORT  = 3'd4;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_TWO  = 8'h32;

  localparam logic [7:0] ID_DIGITS = 8'd4;

  typedef struct packed {
    logic [1:0] reply;
    logic [2:0] event_res;
    logic [7:0] text_byte;
    logic [7:0] text_position;
    logic [7:0] element_number;
    logic [3:0] element_id;
    logic [1:0] element_kind;
    logic [7:0] speed;
    logic [7:0] element_total;
    logic       display_flash;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/display_message_frame_parser_unit.sv =====
// Display message frame parser: byte-wise frame parse with a two-word result buffer.
//
//  channel | signals                          | direction | notes
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid in_ready rx_byte        | to block  | one received byte a word
//  out     | out_valid out_ready reply..flash | from block| one result word per byte
//  cfg     | psel penable pwrite paddr pwdata | to block  | four 8-bit registers
//          | prdata pready                    | from block| pready tied high
//
// One byte per cycle while in_ready is high: the parse step is one state transition
// between the state registers and the result register, or the skid word while the
// result register is held. The output register plus one skid word let input take one
// more byte while out_ready is low; in_ready drops only when both are full.
// rst is synchronous: state idle, counters and held fields zero, registers to defaults.
`default_nettype none
module display_message_frame_parser_unit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [dmfp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [dmfp_pkg::DATA_W-1:0] pwdata,
  output logic      [dmfp_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [7:0]               rx_byte,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    reply,
  output logic [2:0]                    event_res,
  output logic [7:0]                    text_byte,
  output logic [7:0]                    text_position,
  output logic [7:0]                    element_number,
  output logic [3:0]                    element_id,
  output logic [1:0]                    element_kind,
  output logic [7:0]                    speed,
  output logic [7:0]                    element_total,
  output logic                          display_flash
);
  import dmfp_pkg::*;

  logic [7:0] start_byte, id_byte, element_end_byte, transfer_end_byte;

  logic [3:0] parse_state, parse_state_next;
  logic [7:0] total_elements, total_elements_next;
  logic [7:0] current_element, current_element_next;
  logic [7:0] count, count_next;
  logic [7:0] text_length, text_length_next;
  logic [1:0] kind_held, kind_held_next;
  logic [7:0] speed_held, speed_held_next;
  logic [3:0] id_held, id_held_next;
  logic       flash_flag, flash_flag_next;

  res_t res_next, res, skid_res;
  logic skid_valid;
  logic accept;
  logic [7:0] count_inc, element_inc;

  assign pready = 1'b1;
  assign in_ready = !skid_valid;
  assign accept = in_valid && in_ready;
  assign count_inc = count + 8'd1;
  assign element_inc = current_element + 8'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte        <= START_RESET;
      id_byte           <= ID_RESET;
      element_end_byte  <= ELEM_END_RESET;
      transfer_end_byte <= XFER_END_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_START:    start_byte        <= pwdata[7:0];
        REG_ID:       id_byte           <= pwdata[7:0];
        REG_ELEM_END: element_end_byte  <= pwdata[7:0];
        REG_XFER_END: transfer_end_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START:    prdata = {24'd0, start_byte};
      REG_ID:       prdata = {24'd0, id_byte};
      REG_ELEM_END: prdata = {24'd0, element_end_byte};
      REG_XFER_END: prdata = {24'd0, transfer_end_byte};
      default:      prdata = '0;
    endcase
  end

  // Parse step
  always_comb begin
    parse_state_next     = parse_state;
    total_elements_next  = total_elements;
    current_element_next = current_element;
    count_next           = count;
    text_length_next     = text_length;
    kind_held_next       = kind_held;
    speed_held_next      = speed_held;
    id_held_next         = id_held;
    flash_flag_next      = flash_flag;
    res_next             = '0;

    unique case (parse_state)
      ST_ID: begin
        if (rx_byte == id_byte) begin
          parse_state_next = ST_COUNT;
        end else begin
          parse_state_next = ST_IDLE;
          count_next = '0;
          res_next.event_res = EV_ABORT;
        end
      end
      ST_COUNT: begin
        if (rx_byte != 8'd0) begin
          total_elements_next = rx_byte;
          parse_state_next = ST_DIGITS;
          res_next.reply = REPLY_ACK;
        end else begin
          parse_state_next = ST_IDLE;
          count_next = '0;
          res_next.event_res = EV_ABORT;
        end
      end
      ST_DIGITS: begin
        if (rx_byte == CH_ZERO || rx_byte == CH_ONE) begin
          // first digit lands in bit 3
          id_held_next[2'd3 - count[1:0]] = (rx_byte == CH_ONE);
          count_next = count_inc;
          if (count_inc >= ID_DIGITS) begin
            count_next = '0;
            parse_state_next = ST_KIND;
          end
        end else begin
          parse_state_next = ST_IDLE;
          count_next = '0;
          res_next.event_res = EV_ABORT;
        end
      end
      ST_KIND: begin
        if (rx_byte == CH_ZERO || rx_byte == CH_ONE || rx_byte == CH_TWO) begin
          kind_held_next = 2'(rx_byte - CH_ZERO);
          if (rx_byte == CH_TWO) flash_flag_next = 1'b1;
          parse_state_next = ST_SPEED;
        end else begin
          parse_state_next = ST_IDLE;
          count_next = '0;
          res_next.event_res = EV_ABORT;
        end
      end
      ST_SPEED: begin
        if (rx_byte != 8'd0) begin
          speed_held_next = rx_byte;
          parse_state_next = (kind_held == 2'd0) ? ST_LEN : ST_ELEND;
        end else begin
          parse_state_next = ST_IDLE;
          count_next = '0;
          res_next.event_res = EV_ABORT;
        end
      end
      ST_LEN: begin
        if (rx_byte != 8'd0) begin
          text_length_next = rx_byte;
          count_next = '0;
          parse_state_next = ST_TEXT;
        end else begin
          parse_state_next = ST_IDLE;
          count_next = '0;
          res_next.event_res = EV_ABORT;
        end
      end
      ST_TEXT: begin
        // text bytes pass straight through, never answered
        res_next.event_res = EV_TEXT;
        res_next.text_byte = rx_byte;
        res_next.text_position = count;
        res_next.element_number = current_element;
        count_next = count_inc;
        if (count_inc == text_length) begin
          count_next = '0;
          parse_state_next = ST_ELEND;
        end
      end
      ST_ELEND: begin
        if (rx_byte == element_end_byte) begin
          res_next.reply = REPLY_ACK;
          res_next.event_res = EV_ELEM;
          res_next.element_number = current_element;
          res_next.element_id = id_held;
          res_next.element_kind = kind_held;
          res_next.speed = speed_held;
          current_element_next = element_inc;
          count_next = '0;
          parse_state_next = (element_inc == total_elements) ? ST_TXEND : ST_DIGITS;
        end else begin
          parse_state_next = ST_IDLE;
          count_next = '0;
          res_next.event_res = EV_ABORT;
        end
      end
      ST_TXEND: begin
        // hold here on any other byte
        if (rx_byte == transfer_end_byte) begin
          res_next.reply = REPLY_END;
          res_next.event_res = EV_COMMIT;
          res_next.element_total = total_elements;
          current_element_next = '0;
          count_next = '0;
          parse_state_next = ST_IDLE;
        end
      end
      default: begin
        // idle and unused codes
        parse_state_next = ST_IDLE;
        if (rx_byte == start_byte) begin
          flash_flag_next = 1'b0;
          current_element_next = '0;
          count_next = '0;
          parse_state_next = ST_ID;
        end
      end
    endcase

    res_next.display_flash = flash_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= ST_IDLE;
      total_elements  <= '0;
      current_element <= '0;
      count           <= '0;
      text_length     <= '0;
      kind_held       <= '0;
      speed_held      <= '0;
      id_held         <= '0;
      flash_flag      <= 1'b0;
    end else if (accept) begin
      parse_state     <= parse_state_next;
      total_elements  <= total_elements_next;
      current_element <= current_element_next;
      count           <= count_next;
      text_length     <= text_length_next;
      kind_held       <= kind_held_next;
      speed_held      <= speed_held_next;
      id_held         <= id_held_next;
      flash_flag      <= flash_flag_next;
    end
  end

  // Result register and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) res <= skid_res;
      else if (accept) res <= res_next;
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

  assign reply          = res.reply;
  assign event_res      = res.event_res;
  assign text_byte      = res.text_byte;
  assign text_position  = res.text_position;
  assign element_number = res.element_number;
  assign element_id     = res.element_id;
  assign element_kind   = res.element_kind;
  assign speed          = res.speed;
  assign element_total  = res.element_total;
  assign display_flash  = res.display_flash;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the display message frame parser: frame stimulus, prediction, checks.
`default_nettype none
module testbench;
  import dmfp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] reply;
  logic [2:0] event_res;
  logic [7:0] text_byte;
  logic [7:0] text_position;
  logic [7:0] element_number;
  logic [3:0] element_id;
  logic [1:0] element_kind;
  logic [7:0] speed;
  logic [7:0] element_total;
  logic       display_flash;

  display_message_frame_parser_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .reply(reply), .event_res(event_res), .text_byte(text_byte),
    .text_position(text_position), .element_number(element_number),
    .element_id(element_id), .element_kind(element_kind), .speed(speed),
    .element_total(element_total), .display_flash(display_flash)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register copies as the parser should hold them
  logic [7:0] cfg_start    = START_RESET;
  logic [7:0] cfg_id       = ID_RESET;
  logic [7:0] cfg_elem_end = ELEM_END_RESET;
  logic [7:0] cfg_xfer_end = XFER_END_RESET;

  // Parser state mirror
  logic [3:0] p_state = ST_IDLE;
  logic [7:0] p_total = '0;
  logic [7:0] p_elem  = '0;
  logic [7:0] p_count = '0;
  logic [7:0] p_len   = '0;
  logic [1:0] p_kind  = '0;
  logic [7:0] p_speed = '0;
  logic [3:0] p_id    = '0;
  logic       p_flash = 1'b0;

  logic [7:0] rx_pending [$];
  res_t       result_due [$];

  int  mismatches = 0;
  int  phase_no = 0;
  int  in_gap_pct = 12;
  int  out_stall_pct = 12;
  bit  in_fire = 1'b0;
  bit  rx_hold = 1'b0;

  function automatic res_t parse_byte(input logic [7:0] b);
    res_t       r;
    logic [1:0] bit_pos;
    bit         bad;
    r = '0;
    bad = 1'b0;
    case (p_state)
      ST_ID: begin
        if (b == cfg_id) p_state = ST_COUNT;
        else bad = 1'b1;
      end
      ST_COUNT: begin
        if (b != 8'd0) begin
          p_total = b;
          p_state = ST_DIGITS;
          r.reply = REPLY_ACK;
        end else bad = 1'b1;
      end
      ST_DIGITS: begin
        if (b == CH_ZERO || b == CH_ONE) begin
          bit_pos = 2'd3 - p_count[1:0];
          p_id[bit_pos] = (b == CH_ONE);
          p_count = p_count + 8'd1;
          if (p_count >= ID_DIGITS) begin
            p_count = '0;
            p_state = ST_KIND;
          end
        end else bad = 1'b1;
      end
      ST_KIND: begin
        if (b == CH_ZERO || b == CH_ONE || b == CH_TWO) begin
          p_kind = 2'(b - CH_ZERO);
          if (b == CH_TWO) p_flash = 1'b1;
          p_state = ST_SPEED;
        end else bad = 1'b1;
      end
      ST_SPEED: begin
        if (b != 8'd0) begin
          p_speed = b;
          p_state = (p_kind == 2'd0) ? ST_LEN : ST_ELEND;
        end else bad = 1'b1;
      end
      ST_LEN: begin
        if (b != 8'd0) begin
          p_len = b;
          p_count = '0;
          p_state = ST_TEXT;
        end else bad = 1'b1;
      end
      ST_TEXT: begin
        r.event_res = EV_TEXT;
        r.text_byte = b;
        r.text_position = p_count;
        r.element_number = p_elem;
        p_count = p_count + 8'd1;
        if (p_count == p_len) begin
          p_count = '0;
          p_state = ST_ELEND;
        end
      end
      ST_ELEND: begin
        if (b == cfg_elem_end) begin
          r.reply = REPLY_ACK;
          r.event_res = EV_ELEM;
          r.element_number = p_elem;
          r.element_id = p_id;
          r.element_kind = p_kind;
          r.speed = p_speed;
          p_elem = p_elem + 8'd1;
          p_count = '0;
          p_state = (p_elem == p_total) ? ST_TXEND : ST_DIGITS;
        end else bad = 1'b1;
      end
      ST_TXEND: begin
        // anything but the end mark is ignored here
        if (b == cfg_xfer_end) begin
          r.reply = REPLY_END;
          r.event_res = EV_COMMIT;
          r.element_total = p_total;
          p_elem = '0;
          p_count = '0;
          p_state = ST_IDLE;
        end
      end
      default: begin
        p_state = ST_IDLE;
        if (b == cfg_start) begin
          p_flash = 1'b0;
          p_elem = '0;
          p_count = '0;
          p_state = ST_ID;
        end
      end
    endcase
    if (bad) begin
      p_state = ST_IDLE;
      p_count = '0;
      r.event_res = EV_ABORT;
    end
    r.display_flash = p_flash;
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    logic [23:0] upper;
    upper = 24'($urandom);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {upper, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START:    cfg_start = val;
      REG_ID:       cfg_id = val;
      REG_ELEM_END: cfg_elem_end = val;
      default:      cfg_xfer_end = val;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] s, input logic [7:0] i,
                          input logic [7:0] e, input logic [7:0] x);
    write_reg(REG_START, s);
    write_reg(REG_ID, i);
    write_reg(REG_ELEM_END, e);
    write_reg(REG_XFER_END, x);
  endtask

  // Build one frame with the current framing bytes; some get a byte hit or are cut short.
  task automatic queue_frame();
    logic [7:0] f [$];
    logic [7:0] b;
    int n, e, d, kind, len, i, r, cut;
    n = ($urandom_range(99) < 95) ? $urandom_range(4, 1) : $urandom_range(255, 1);
    f.push_back(cfg_start);
    f.push_back(cfg_id);
    b = 8'(n);
    f.push_back(b);
    for (e = 0; e < n && e < 6; e++) begin
      for (d = 0; d < 4; d++) f.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
      kind = $urandom_range(2);
      b = 8'(kind);
      f.push_back(CH_ZERO + b);
      b = 8'($urandom_range(255, 1));
      f.push_back(b);
      if (kind == 0) begin
        r = $urandom_range(99);
        len = (r < 90) ? $urandom_range(6, 1) : (r < 97) ? $urandom_range(255, 1) : 255;
        b = 8'(len);
        f.push_back(b);
        for (i = 0; i < len; i++) begin
          b = 8'($urandom);
          f.push_back(b);
        end
      end
      f.push_back(cfg_elem_end);
    end
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(2, 1)) begin
        do b = 8'($urandom); while (b == cfg_xfer_end);
        f.push_back(b);
      end
    end
    f.push_back(cfg_xfer_end);
    r = $urandom_range(99);
    if (r < 8) begin
      b = 8'($urandom);
      f[$urandom_range(f.size() - 1)] = b;
    end else if (r < 12) begin
      cut = $urandom_range(f.size() - 1, 1);
      while (f.size() > cut) void'(f.pop_back());
    end
    foreach (f[k]) rx_pending.push_back(f[k]);
  endtask

  task automatic fill_random(input int target);
    logic [7:0] b;
    while (rx_pending.size() < target) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(4, 1)) begin
          b = 8'($urandom);
          rx_pending.push_back(b);
        end
      end else begin
        queue_frame();
      end
    end
  endtask

  // Sender: offer the next word, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (rx_pending.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
        rx_byte <= rx_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Long receiver hold-off while the sender keeps offering words
  initial begin : hold_off
    int k;
    while (phase_no != 2) @(posedge clk);
    repeat (40) @(posedge clk);
    rx_hold = 1'b1;
    for (k = 0; k < 300; k++) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin : monitor
    res_t want;
    in_fire = in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (result_due.size() == 0) begin
          $error("result word with nothing due");
          mismatches++;
        end else begin
          want = result_due.pop_front();
          if (reply !== want.reply) begin
            $error("reply: expected %0d, got %0d", want.reply, reply);
            mismatches++;
          end
          if (event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, event_res);
            mismatches++;
          end
          if (text_byte !== want.text_byte) begin
            $error("text_byte: expected %0d, got %0d", want.text_byte, text_byte);
            mismatches++;
          end
          if (text_position !== want.text_position) begin
            $error("text_position: expected %0d, got %0d", want.text_position, text_position);
            mismatches++;
          end
          if (element_number !== want.element_number) begin
            $error("element_number: expected %0d, got %0d", want.element_number,
                   element_number);
            mismatches++;
          end
          if (element_id !== want.element_id) begin
            $error("element_id: expected %0d, got %0d", want.element_id, element_id);
            mismatches++;
          end
          if (element_kind !== want.element_kind) begin
            $error("element_kind: expected %0d, got %0d", want.element_kind, element_kind);
            mismatches++;
          end
          if (speed !== want.speed) begin
            $error("speed: expected %0d, got %0d", want.speed, speed);
            mismatches++;
          end
          if (element_total !== want.element_total) begin
            $error("element_total: expected %0d, got %0d", want.element_total, element_total);
            mismatches++;
          end
          if (display_flash !== want.display_flash) begin
            $error("display_flash: expected %0d, got %0d", want.display_flash, display_flash);
            mismatches++;
          end
        end
      end
      if (in_fire) result_due.push_back(parse_byte(rx_byte));
    end
  end

  initial begin : limit
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : sequence_run
    logic [7:0] directed [0:26];
    logic [7:0] s, i, e, x;
    directed = '{8'h00, 8'hFF,
                 START_RESET, ID_RESET, 8'h00,
                 START_RESET, ID_RESET, 8'd2,
                 CH_ONE, CH_ZERO, CH_ONE, CH_ONE, CH_ZERO, 8'hFF, 8'd2, 8'h01, 8'hFF,
                 ELEM_END_RESET,
                 CH_ZERO, CH_ONE, CH_ZERO, CH_ZERO, CH_TWO, 8'd1, ELEM_END_RESET,
                 8'h00, XFER_END_RESET};
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    for (phase_no = 0; phase_no < 6; phase_no++) begin
      case (phase_no)
        0: foreach (directed[k]) rx_pending.push_back(directed[k]);
        1: set_regs(8'h00, 8'h00, 8'h00, 8'h00);
        2: set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3, 4: begin
          s = 8'($urandom);
          i = 8'($urandom);
          e = 8'($urandom);
          x = 8'($urandom);
          set_regs(s, i, e, x);
        end
        default: set_regs(START_RESET, ID_RESET, ELEM_END_RESET, XFER_END_RESET);
      endcase
      in_gap_pct = (phase_no == 1) ? 0 : 12;
      out_stall_pct = (phase_no == 1) ? 0 : 12;
      fill_random(290);
      // drain before touching the registers again
      while (rx_pending.size() != 0 || in_valid || result_due.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/dmfp_pkg.sv
rtl/display_message_frame_parser_unit.sv
verif/testbench.sv
